// ----- hdl/lafm_pkg.sv -----
// Shared types and constants of the LRU address-to-fingerprint map.
// No dependencies; used by lru_address_fingerprint_map, lafm_result_checker and the testbench top.
package lafm_pkg;

  localparam int DefEntries  = 64;
  localparam int DefFpBytes  = 16;
  localparam int CapResetMax = 64;
  localparam int CapW        = 7;
  localparam int ModeW       = 2;
  localparam int AddrW       = 48;
  localparam int HalfW       = 64;
  localparam int FullFpW     = 2 * HalfW;

  typedef enum logic [ModeW-1:0] {
    MODE_LOOKUP  = 2'd0,
    MODE_PROMOTE = 2'd1,
    MODE_UPDATE  = 2'd2
  } mode_e;

endpackage

// ----- hdl/lru_address_fingerprint_map.sv -----
// Fully associative block-address to fingerprint map with LRU replacement.
// Depends on lafm_pkg for field widths, defaults and the mode codes.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  -----------------------------------------------
//  request   start_i high, busy_o low     mode_i, block_address_i, new_fp_low/high_i
//  result    result_valid_o, one cycle    hit_o, evicted_o, capacity_eviction_o, out_fp_*
//  config    capacity_we_i                capacity_i
//
// A request beat is registered, then the tag compare, victim pick, age update and
// fingerprint memory access happen in the following cycle; their outcome is loaded into
// the result register, which drives the ports.
// One beat is taken every cycle; busy_o stays low.
// The registered read port of the fingerprint memory loads with the result register.
// Reset clears all valid bits, ages and occupancy at once; no clearing pass is needed.
// The receiver cannot stall: each result is presented for exactly one cycle.
module lru_address_fingerprint_map #(
  parameter int ENTRIES  = lafm_pkg::DefEntries,
  parameter int FP_BYTES = lafm_pkg::DefFpBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [lafm_pkg::ModeW-1:0]   mode_i,
  input  logic [lafm_pkg::AddrW-1:0]   block_address_i,
  input  logic [lafm_pkg::HalfW-1:0]   new_fp_low_i,
  input  logic [lafm_pkg::HalfW-1:0]   new_fp_high_i,
  input  logic                         capacity_we_i,
  input  logic [lafm_pkg::CapW-1:0]    capacity_i,
  output logic                         result_valid_o,
  output logic                         hit_o,
  output logic                         evicted_o,
  output logic                         capacity_eviction_o,
  output logic [lafm_pkg::HalfW-1:0]   out_fp_low_o,
  output logic [lafm_pkg::HalfW-1:0]   out_fp_high_o
);

  localparam int IdxW     = $clog2(ENTRIES);
  localparam int AgeW     = $clog2(ENTRIES);
  localparam int CntW     = $clog2(ENTRIES + 1);
  localparam int CmpW     = (CntW > lafm_pkg::CapW) ? CntW : lafm_pkg::CapW;
  localparam int FpW      = 8 * FP_BYTES;
  localparam int CapReset = (ENTRIES < lafm_pkg::CapResetMax) ? ENTRIES : lafm_pkg::CapResetMax;

  // Request register.
  logic                             req_valid_q;
  logic [lafm_pkg::ModeW-1:0]       mode_q;
  logic [lafm_pkg::AddrW-1:0]       addr_q;
  logic [FpW-1:0]                   new_fp_q;
  logic [lafm_pkg::FullFpW-1:0]     new_fp_full;

  // Table state.
  logic [ENTRIES-1:0]               valid_q, valid_d;
  logic [AgeW-1:0]                  age_q [ENTRIES];
  logic [AgeW-1:0]                  age_d [ENTRIES];
  logic [lafm_pkg::AddrW-1:0]       tag_q [ENTRIES];
  logic [CntW-1:0]                  occ_q, occ_d;
  logic [CntW-1:0]                  occ_m1;
  logic [CntW-1:0]                  capacity_q, capacity_d;
  logic [CmpW-1:0]                  cap_clamp;

  logic [FpW-1:0]                   fp_mem [ENTRIES];
  logic [FpW-1:0]                   rd_q;

  // Per-item decode.
  logic [ENTRIES-1:0]               hit_oh, victim_oh, valid_left;
  logic [IdxW-1:0]                  hit_idx, victim_idx, free_idx, rd_idx, wr_idx;
  logic [AgeW-1:0]                  hit_age;
  logic                             any_hit, free_found;
  logic                             do_hit_move, do_insert, do_evict, do_write;
  logic                             res_hit, res_evicted, res_cap_ev, res_fp_use;
  logic                             tag_we;

  // Result register.
  logic                             res_valid_q, res_hit_q, res_evicted_q, res_cap_ev_q;
  logic                             res_fp_use_q;
  logic [lafm_pkg::FullFpW-1:0]     out_fp_full;

  assign busy_o      = 1'b0;
  assign new_fp_full = {new_fp_high_i, new_fp_low_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      mode_q   <= mode_i;
      addr_q   <= block_address_i;
      new_fp_q <= new_fp_full[FpW-1:0];
    end
  end

  // Tag match, victim select and age bookkeeping. Ages of valid entries always form
  // a permutation of 0 .. occupancy-1, so the least recent entry is the one whose
  // age equals occupancy-1.
  assign occ_m1 = occ_q - CntW'(1);

  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    hit_age = '0;
    victim_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh[i]    = valid_q[i] && (tag_q[i] == addr_q);
      victim_oh[i] = valid_q[i] && (age_q[i] == occ_m1[AgeW-1:0]);
      if (hit_oh[i]) begin
        hit_idx = hit_idx | IdxW'(i);
        hit_age = hit_age | age_q[i];
      end
      if (victim_oh[i]) begin
        victim_idx = victim_idx | IdxW'(i);
      end
      any_hit = any_hit | hit_oh[i];
    end
  end

  always_comb begin
    do_hit_move = 1'b0;
    do_insert   = 1'b0;
    do_evict    = 1'b0;
    res_hit     = 1'b0;
    res_evicted = 1'b0;
    res_cap_ev  = 1'b0;
    res_fp_use  = 1'b0;
    if (req_valid_q) begin
      unique case (lafm_pkg::mode_e'(mode_q))
        lafm_pkg::MODE_LOOKUP: begin
          res_hit    = any_hit;
          res_fp_use = any_hit;
        end
        lafm_pkg::MODE_PROMOTE: begin
          res_hit     = any_hit;
          do_hit_move = any_hit;
        end
        lafm_pkg::MODE_UPDATE: begin
          res_hit     = any_hit;
          do_hit_move = any_hit;
          do_insert   = !any_hit;
          do_evict    = !any_hit && (occ_q >= capacity_q) && (victim_oh != '0);
          res_evicted = any_hit || do_evict;
          res_cap_ev  = do_evict;
          res_fp_use  = any_hit || do_evict;
        end
        default: begin
        end
      endcase
    end
  end

  assign valid_left = valid_q & ~(do_evict ? victim_oh : '0);

  // Lowest-numbered free slot once the victim, if any, has been dropped.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_left[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign tag_we   = do_insert && free_found;
  assign do_write = do_hit_move || tag_we;
  assign wr_idx   = do_hit_move ? hit_idx : free_idx;
  assign rd_idx   = any_hit ? hit_idx : victim_idx;

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
    end
    if (do_hit_move) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_oh[i]) begin
          age_d[i] = '0;
        end else if (valid_q[i] && (age_q[i] < hit_age)) begin
          age_d[i] = age_q[i] + AgeW'(1);
        end
      end
    end else if (do_insert) begin
      valid_d = valid_left;
      occ_d   = do_evict ? occ_m1 : occ_q;
      if (tag_we) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_idx == IdxW'(i)) begin
            age_d[i] = '0;
          end else if (valid_left[i]) begin
            age_d[i] = age_q[i] + AgeW'(1);
          end
        end
        valid_d[free_idx] = 1'b1;
        occ_d = occ_d + CntW'(1);
      end
    end
  end

  // A capacity write takes effect only while the table is empty.
  always_comb begin
    cap_clamp = CmpW'(capacity_i);
    if (cap_clamp == '0) begin
      cap_clamp = CmpW'(1);
    end
    if (cap_clamp > CmpW'(ENTRIES)) begin
      cap_clamp = CmpW'(ENTRIES);
    end
    capacity_d = capacity_q;
    if (capacity_we_i && (occ_q == '0)) begin
      capacity_d = cap_clamp[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      occ_q      <= '0;
      capacity_q <= CntW'(CapReset);
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q    <= valid_d;
      occ_q      <= occ_d;
      capacity_q <= capacity_d;
      age_q      <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_q[free_idx] <= addr_q;
    end
  end

  // Fingerprint store: the read returns the contents from before a same-cycle write.
  always_ff @(posedge clk_i) begin
    rd_q <= fp_mem[rd_idx];
    if (do_write && (lafm_pkg::mode_e'(mode_q) == lafm_pkg::MODE_UPDATE)) begin
      fp_mem[wr_idx] <= new_fp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q     <= res_hit;
    res_evicted_q <= res_evicted;
    res_cap_ev_q  <= res_cap_ev;
    res_fp_use_q  <= res_fp_use;
  end

  always_comb begin
    out_fp_full = '0;
    if (res_fp_use_q) begin
      out_fp_full[FpW-1:0] = rd_q;
    end
  end

  assign result_valid_o      = res_valid_q;
  assign hit_o               = res_valid_q & res_hit_q;
  assign evicted_o           = res_valid_q & res_evicted_q;
  assign capacity_eviction_o = res_valid_q & res_cap_ev_q;
  assign out_fp_low_o        = out_fp_full[lafm_pkg::HalfW-1:0];
  assign out_fp_high_o       = out_fp_full[lafm_pkg::FullFpW-1:lafm_pkg::HalfW];

  // Every registered request beat produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> result_valid_o)
    else $error("request beat produced no result");

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match valid entries");

  a_occ_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= capacity_q)
    else $error("occupancy exceeds capacity");

  a_cap_ev_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capacity_eviction_o |-> (evicted_o && !hit_o))
    else $error("capacity eviction flagged on a hit");

endmodule

// ----- tb/lafm_result_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for lru_address_fingerprint_map: keeps its own copy of the LRU table,
// predicts the reply to every accepted request beat and compares each reply beat.
// Depends on lafm_pkg for field widths, the reset capacity and the mode codes.
module lafm_result_checker #(
  parameter int ENTRIES  = lafm_pkg::DefEntries,
  parameter int FP_BYTES = lafm_pkg::DefFpBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [lafm_pkg::ModeW-1:0]   mode_i,
  input  logic [lafm_pkg::AddrW-1:0]   block_address_i,
  input  logic [lafm_pkg::HalfW-1:0]   new_fp_low_i,
  input  logic [lafm_pkg::HalfW-1:0]   new_fp_high_i,
  input  logic                         capacity_we_i,
  input  logic [lafm_pkg::CapW-1:0]    capacity_i,
  input  logic                         result_valid_i,
  input  logic                         hit_i,
  input  logic                         evicted_i,
  input  logic                         capacity_eviction_i,
  input  logic [lafm_pkg::HalfW-1:0]   out_fp_low_i,
  input  logic [lafm_pkg::HalfW-1:0]   out_fp_high_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           cap_evictions_o
);

  localparam int FpW    = lafm_pkg::FullFpW;
  localparam int HalfW  = lafm_pkg::HalfW;
  localparam int AddrW  = lafm_pkg::AddrW;
  localparam int ResetCap = (ENTRIES < lafm_pkg::CapResetMax) ? ENTRIES : lafm_pkg::CapResetMax;
  localparam logic [FpW-1:0] FpOne  = 1;
  localparam logic [FpW-1:0] FpMask = (FP_BYTES >= 16) ? {FpW{1'b1}} :
                                      (FpOne << (8 * FP_BYTES)) - FpOne;
  localparam int unsigned AgeAll = 32'hFFFF_FFFF;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             cap_evict;
    logic [HalfW-1:0] fp_low;
    logic [HalfW-1:0] fp_high;
  } map_reply_t;

  logic             tag_valid [ENTRIES];
  logic [AddrW-1:0] tag_addr  [ENTRIES];
  logic [FpW-1:0]   tag_fp    [ENTRIES];
  int unsigned      tag_age   [ENTRIES];
  int unsigned      fill_level;
  int unsigned      cap_limit;
  map_reply_t       lookup_replies_q [$];

  // Slot becomes most recent; every other valid entry younger than the limit ages by one.
  task automatic make_most_recent(input int slot, input int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != slot && tag_valid[i] && tag_age[i] < limit) tag_age[i]++;
    end
    tag_age[slot] = 0;
  endtask

  task automatic apply_map_access(input logic [lafm_pkg::ModeW-1:0] mode,
                                  input logic [AddrW-1:0] addr,
                                  input logic [FpW-1:0] fp_in,
                                  output map_reply_t reply);
    int slot;
    int victim;
    logic [FpW-1:0] fp_new;
    fp_new = fp_in & FpMask;
    reply  = '0;
    slot   = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && tag_valid[i] && tag_addr[i] == addr) slot = i;
    end
    case (mode)
      lafm_pkg::MODE_LOOKUP: begin
        if (slot >= 0) begin
          reply.hit = 1'b1;
          {reply.fp_high, reply.fp_low} = tag_fp[slot];
        end
      end
      lafm_pkg::MODE_PROMOTE: begin
        if (slot >= 0) begin
          reply.hit = 1'b1;
          make_most_recent(slot, tag_age[slot]);
        end
      end
      lafm_pkg::MODE_UPDATE: begin
        if (slot >= 0) begin
          reply.hit     = 1'b1;
          reply.evicted = 1'b1;
          {reply.fp_high, reply.fp_low} = tag_fp[slot];
          make_most_recent(slot, tag_age[slot]);
        end else begin
          if (fill_level >= cap_limit) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (tag_valid[i] && (victim < 0 || tag_age[i] > tag_age[victim])) victim = i;
            end
            if (victim >= 0) begin
              reply.evicted   = 1'b1;
              reply.cap_evict = 1'b1;
              {reply.fp_high, reply.fp_low} = tag_fp[victim];
              tag_valid[victim] = 1'b0;
              fill_level--;
            end
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !tag_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            tag_valid[slot] = 1'b1;
            tag_addr[slot]  = addr;
            fill_level++;
            make_most_recent(slot, AgeAll);
          end
        end
        if (slot >= 0) tag_fp[slot] = fp_new;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    map_reply_t predicted;
    map_reply_t wanted;
    map_reply_t got;
    int unsigned cap_val;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_valid[i] = 1'b0;
        tag_addr[i]  = '0;
        tag_fp[i]    = '0;
        tag_age[i]   = 0;
      end
      fill_level = 0;
      cap_limit  = ResetCap;
      lookup_replies_q.delete();
      pending_o       = 0;
      fail_count_o    = 0;
      checked_o       = 0;
      cap_evictions_o = 0;
    end else begin
      // The capacity register only takes a write while the table is empty.
      if (capacity_we_i && fill_level == 0) begin
        cap_val = capacity_i;
        if (cap_val < 1) cap_val = 1;
        if (cap_val > ENTRIES) cap_val = ENTRIES;
        cap_limit = cap_val;
      end
      if (start_i && !busy_i) begin
        apply_map_access(mode_i, block_address_i, {new_fp_high_i, new_fp_low_i}, predicted);
        lookup_replies_q.push_back(predicted);
      end
      if (result_valid_i) begin
        got = {hit_i, evicted_i, capacity_eviction_i, out_fp_low_i, out_fp_high_i};
        if (lookup_replies_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display("%0t: reply beat with no request waiting: hit %b evicted %b cap_evict %b fp %h_%h",
                     $realtime, got.hit, got.evicted, got.cap_evict, got.fp_high, got.fp_low);
        end else begin
          wanted = lookup_replies_q.pop_front();
          checked_o++;
          if (wanted.cap_evict) cap_evictions_o++;
          if (got !== wanted) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports) begin
              $display("%0t: reply mismatch, expected hit %b evicted %b cap_evict %b fp %h_%h",
                       $realtime, wanted.hit, wanted.evicted, wanted.cap_evict,
                       wanted.fp_high, wanted.fp_low);
              $display("%0t:                 actual   hit %b evicted %b cap_evict %b fp %h_%h",
                       $realtime, got.hit, got.evicted, got.cap_evict, got.fp_high, got.fp_low);
            end
          end
        end
      end
      pending_o = lookup_replies_q.size();
    end
  end

endmodule

// ----- tb/lru_address_fingerprint_map_tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench: drives request and capacity beats into the LRU fingerprint map
// and gives the verdict. Depends on lafm_pkg, the block and lafm_result_checker.
module lru_address_fingerprint_map_tb;

  localparam int Entries     = lafm_pkg::DefEntries;
  localparam int FpBytes     = lafm_pkg::DefFpBytes;
  localparam int ModeW       = lafm_pkg::ModeW;
  localparam int AddrW       = lafm_pkg::AddrW;
  localparam int HalfW       = lafm_pkg::HalfW;
  localparam int CapW        = lafm_pkg::CapW;
  // The fourth mode code is unused by the block and must act as a no-op.
  localparam logic [ModeW-1:0] ModeReserved = 2'd3;
  localparam int MaxGap      = 11;
  localparam int RandomItems = 1030;
  localparam int PoolSize    = 128;
  localparam int TailCycles  = 6;
  localparam int TimeoutNs   = 3_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [ModeW-1:0]    mode_i;
  logic [AddrW-1:0]    block_address_i;
  logic [HalfW-1:0]    new_fp_low_i;
  logic [HalfW-1:0]    new_fp_high_i;
  logic                capacity_we_i;
  logic [CapW-1:0]     capacity_i;
  logic                result_valid_o;
  logic                hit_o;
  logic                evicted_o;
  logic                capacity_eviction_o;
  logic [HalfW-1:0]    out_fp_low_o;
  logic [HalfW-1:0]    out_fp_high_o;

  int fail_count;
  int pending;
  int checked;
  int cap_evictions;

  bit          no_idle;
  int          beats_sent;
  int          pool_n;
  int unsigned cap_setting;
  logic [AddrW-1:0] addr_pool [PoolSize];

  lru_address_fingerprint_map #(
    .ENTRIES (Entries),
    .FP_BYTES(FpBytes)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .mode_i             (mode_i),
    .block_address_i    (block_address_i),
    .new_fp_low_i       (new_fp_low_i),
    .new_fp_high_i      (new_fp_high_i),
    .capacity_we_i      (capacity_we_i),
    .capacity_i         (capacity_i),
    .result_valid_o     (result_valid_o),
    .hit_o              (hit_o),
    .evicted_o          (evicted_o),
    .capacity_eviction_o(capacity_eviction_o),
    .out_fp_low_o       (out_fp_low_o),
    .out_fp_high_o      (out_fp_high_o)
  );

  lafm_result_checker #(
    .ENTRIES (Entries),
    .FP_BYTES(FpBytes)
  ) i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .mode_i             (mode_i),
    .block_address_i    (block_address_i),
    .new_fp_low_i       (new_fp_low_i),
    .new_fp_high_i      (new_fp_high_i),
    .capacity_we_i      (capacity_we_i),
    .capacity_i         (capacity_i),
    .result_valid_i     (result_valid_o),
    .hit_i              (hit_o),
    .evicted_i          (evicted_o),
    .capacity_eviction_i(capacity_eviction_o),
    .out_fp_low_i       (out_fp_low_o),
    .out_fp_high_i      (out_fp_high_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked),
    .cap_evictions_o    (cap_evictions)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #TimeoutNs;
    $display("Timeout with %0d replies still outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [HalfW-1:0] random_fp_half();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '1;
    if (pick == 1) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // Mostly addresses from a pool of the capacity plus half of it plus four, so hits and evictions are common.
  function automatic logic [AddrW-1:0] pick_address();
    logic [2*32-1:0] raw;
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, pool_n - 1)];
    raw = {$urandom(), $urandom()};
    return raw[AddrW-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [ModeW-1:0] mode, input logic [AddrW-1:0] addr,
                           input logic [HalfW-1:0] fp_low, input logic [HalfW-1:0] fp_high);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i          = mode;
    block_address_i = addr;
    new_fp_low_i    = fp_low;
    new_fp_high_i   = fp_high;
    start_i         = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    capacity_i    = value;
    capacity_we_i = 1'b1;
    @(negedge clk_i);
    capacity_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [ModeW-1:0] mode;
    int roll;
    int counted;
    bit paused;
    logic [2*32-1:0] raw;
    start_i         = 1'b0;
    mode_i          = lafm_pkg::MODE_LOOKUP;
    block_address_i = '0;
    new_fp_low_i    = '0;
    new_fp_high_i   = '0;
    capacity_we_i   = 1'b0;
    capacity_i      = '0;
    rst_ni          = 1'b0;
    no_idle         = 1'b0;
    beats_sent      = 0;
    counted         = 0;
    paused          = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // While the table is empty every write lands; only the last one shapes the run.
    write_capacity('0);
    write_capacity('1);
    case ($urandom_range(0, 3))
      0:       cap_setting = 1;
      1:       cap_setting = Entries;
      default: cap_setting = $urandom_range(2, Entries - 1);
    endcase
    write_capacity(CapW'(cap_setting));
    pool_n = cap_setting + cap_setting / 2 + 4;
    if (pool_n > PoolSize) pool_n = PoolSize;
    for (int i = 0; i < PoolSize; i++) begin
      raw = {$urandom(), $urandom()};
      addr_pool[i] = raw[AddrW-1:0];
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;

    // Directed beats: empty-table misses, absent promote, reserved mode, hits and refresh.
    send_beat(lafm_pkg::MODE_LOOKUP, '0, '1, '1);
    send_beat(lafm_pkg::MODE_PROMOTE, '1, '0, '0);
    send_beat(ModeReserved, '1, '1, '1);
    send_beat(lafm_pkg::MODE_UPDATE, '0, '1, '1);
    send_beat(lafm_pkg::MODE_UPDATE, '1, '0, '0);
    send_beat(lafm_pkg::MODE_LOOKUP, '0, '0, '0);
    send_beat(lafm_pkg::MODE_LOOKUP, '1, '0, '0);
    send_beat(lafm_pkg::MODE_PROMOTE, '0, '1, '1);
    send_beat(lafm_pkg::MODE_UPDATE, '0, {(HalfW/2){2'b10}}, {(HalfW/2){2'b01}});
    for (int i = 2; i < 10; i++)
      send_beat(lafm_pkg::MODE_UPDATE, addr_pool[i], random_fp_half(), random_fp_half());
    send_beat(lafm_pkg::MODE_LOOKUP, addr_pool[2], '0, '0);
    send_beat(lafm_pkg::MODE_LOOKUP, addr_pool[9], '0, '0);
    send_beat(ModeReserved, '0, '0, '0);

    // The table now holds entries, so these writes must leave the capacity alone.
    wait_idle();
    write_capacity('0);
    write_capacity('1);

    while (counted < RandomItems) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if (!paused && counted == RandomItems / 2) begin
        wait_idle();
        write_capacity(CapW'($urandom()));
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 36)      mode = lafm_pkg::MODE_UPDATE;
      else if (roll < 70) mode = lafm_pkg::MODE_LOOKUP;
      else if (roll < 95) mode = lafm_pkg::MODE_PROMOTE;
      else                mode = ModeReserved;
      send_beat(mode, pick_address(), random_fp_half(), random_fp_half());
      if (mode != ModeReserved) counted++;
    end
    wait_idle();

    $display("Run covered %0d request beats at capacity %0d, %0d replies checked, %0d capacity evictions.",
             beats_sent, cap_setting, checked, cap_evictions);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatching or unexpected reply beats.", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
